[rtl/core/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared request and response types, request codes and status codes for the
// positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

	// Request codes.
	localparam logic [2:0] REQ_INS_FRONT = 3'd0;
	localparam logic [2:0] REQ_INS_BACK  = 3'd1;
	localparam logic [2:0] REQ_INS_AT    = 3'd2;
	localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
	localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
	localparam logic [2:0] REQ_DEL_AT    = 3'd5;
	localparam logic [2:0] REQ_READ_AT   = 3'd6;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
		logic [7:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         size_now;
		logic signed [31:0] read_value;
	} rsp_t;

	// Decoded action for the storage cells and the result register.
	typedef struct packed {
		logic       ins;
		logic       del;
		logic       rd;
		logic [1:0] status;
	} op_t;

endpackage

[rtl/core/pls_ctrl.sv]
// ----------------------------------------------------------------------------
// pls_ctrl
// Decodes one request against the current size: checks the position, the
// full and empty conditions, and picks the cell index and the next size.
// ----------------------------------------------------------------------------
module pls_ctrl #(
	parameter int CAPACITY = 32
) (
	input  pls_pkg::req_t                     req,
	input  logic [$clog2(CAPACITY+1)-1:0]     size,
	output pls_pkg::op_t                      op,
	output logic [$clog2(CAPACITY)-1:0]       idx,
	output logic [$clog2(CAPACITY+1)-1:0]     size_nxt
);

	localparam int IW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);
	localparam int CW = (SW + 1 > 9) ? SW + 1 : 9;

	logic [CW-1:0] pos_c;
	logic [CW-1:0] size_c;
	logic          full;
	logic          empty;
	logic          pos_zero;

	assign pos_c    = CW'(req.position);
	assign size_c   = CW'(size);
	assign full     = (size_c == CW'(CAPACITY));
	assign empty    = (size == '0);
	assign pos_zero = (req.position == 8'd0);

	always_comb begin
		op     = '{ins: 1'b0, del: 1'b0, rd: 1'b0, status: pls_pkg::ST_OK};
		idx    = '0;
		unique case (req.req_type)
			pls_pkg::REQ_INS_FRONT: begin
				if (full) op.status = pls_pkg::ST_FULL;
				else op.ins = 1'b1;
			end
			pls_pkg::REQ_INS_BACK: begin
				if (full) op.status = pls_pkg::ST_FULL;
				else op.ins = 1'b1;
				idx = IW'(size);
			end
			pls_pkg::REQ_INS_AT: begin
				if (pos_zero || pos_c > size_c + CW'(1)) op.status = pls_pkg::ST_BADPOS;
				else if (full) op.status = pls_pkg::ST_FULL;
				else op.ins = 1'b1;
				idx = IW'(pos_c - CW'(1));
			end
			pls_pkg::REQ_DEL_FRONT: begin
				if (empty) op.status = pls_pkg::ST_EMPTY;
				else op.del = 1'b1;
			end
			pls_pkg::REQ_DEL_BACK: begin
				if (empty) op.status = pls_pkg::ST_EMPTY;
				else op.del = 1'b1;
				idx = IW'(size_c - CW'(1));
			end
			pls_pkg::REQ_DEL_AT: begin
				if (empty) op.status = pls_pkg::ST_EMPTY;
				else if (pos_zero || pos_c > size_c) op.status = pls_pkg::ST_BADPOS;
				else op.del = 1'b1;
				idx = IW'(pos_c - CW'(1));
			end
			pls_pkg::REQ_READ_AT: begin
				if (pos_zero || pos_c > size_c) op.status = pls_pkg::ST_BADPOS;
				else op.rd = 1'b1;
				idx = IW'(pos_c - CW'(1));
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (op.ins) size_nxt = size + SW'(1);
		else if (op.del) size_nxt = size - SW'(1);
		else size_nxt = size;
	end

endmodule

[rtl/core/pls_cells.sv]
// ----------------------------------------------------------------------------
// pls_cells
// Row of storage cells. Each cell compares its own index with the request
// index and takes the new value, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module pls_cells #(
	parameter int CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        upd,
	input  pls_pkg::op_t                op,
	input  logic [$clog2(CAPACITY)-1:0] idx,
	input  logic signed [31:0]          value,
	output logic signed [31:0]          rd_data
);

	localparam int IW = $clog2(CAPACITY);

	logic signed [31:0] entries_q [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left;
		logic signed [31:0] right;

		if (i == 0) begin : g_first
			assign left = value;
		end else begin : g_mid_l
			assign left = entries_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = entries_q[i];
		end else begin : g_mid_r
			assign right = entries_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (upd && op.ins) begin
				if (IW'(i) == idx) entries_q[i] <= value;
				else if (IW'(i) > idx) entries_q[i] <= left;
			end else if (upd && op.del) begin
				if (IW'(i) >= idx) entries_q[i] <= right;
			end
		end
	end

	assign rd_data = entries_q[idx];

endmodule

[rtl/core/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed 32-bit values; insert/delete at front, back
// or any 1-based position, read at any position; one response per request.
// ----------------------------------------------------------------------------
//
//   channel  | signals                        | direction
//   ---------+--------------------------------+----------
//   request  | req_valid, req_ready, req      | in
//   response | rsp_valid, rsp_ready, rsp      | out
//
// Each request waits in the input register and is decoded and applied to the
// cell row as it moves into the response register, so a new request is taken
// every cycle while responses are drained.
// The cells shift in parallel; the only per-request loop is the row of
// CAPACITY cell compares.
// Reset clears the size and the handshake state; cell contents are left as is.
// A stalled response holds the input register, which then drops req_ready.
//
module positional_list_store #(
	parameter int CAPACITY = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  pls_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pls_pkg::rsp_t  rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);

	// Input register.
	logic          valid_s1;
	pls_pkg::req_t req_s1;

	// Stored size and response register.
	logic [SW-1:0] size_q;
	logic          rsp_valid_q;
	pls_pkg::rsp_t rsp_q;

	// Decode results.
	pls_pkg::op_t       op;
	logic [IW-1:0]      idx;
	logic [SW-1:0]      size_nxt;
	logic signed [31:0] rd_data;
	logic               advance;

	// The request in the input register moves on when the response slot is
	// free or being emptied in this cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	pls_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.req      (req_s1),
		.size     (size_q),
		.op       (op),
		.idx      (idx),
		.size_nxt (size_nxt)
	);

	pls_cells #(
		.CAPACITY (CAPACITY)
	) u_cells (
		.clk     (clk),
		.upd     (advance),
		.op      (op),
		.idx     (idx),
		.value   (req_s1.value),
		.rd_data (rd_data)
	);

	// The size and the cells change together, at the moment the request
	// leaves the input register, so the next request sees the updated list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			size_q      <= size_nxt;
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Accepted reads return the stored word; every other request returns zero.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.status     <= op.status;
			rsp_q.size_now   <= 6'(size_nxt);
			rsp_q.read_value <= op.rd ? rd_data : 32'sd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The size never goes beyond the number of cells.
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= CAPACITY)
		else $error("size exceeds capacity");

	// At most one kind of action is decoded for a request.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0({op.ins, op.del, op.rd}))
		else $error("more than one action decoded");

	// An applied insert grows the list by one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op.ins |=> size_q == $past(size_q) + SW'(1))
		else $error("insert did not grow the size");

	// A refused request leaves the size alone.
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op.status != pls_pkg::ST_OK |=> $stable(size_q))
		else $error("refused request changed the size");

endmodule
